### hdl/rv32im_integer_execute_unit_core_macros.svh
// assertion macros for the execute unit checker
`ifndef RV32IM_INTEGER_EXECUTE_UNIT_CORE_MACROS_SVH
`define RV32IM_INTEGER_EXECUTE_UNIT_CORE_MACROS_SVH
// implication checked every clock, quiet during reset
`define RIX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
// implication whose consequent is checked in the next cycle
`define RIX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/rix_pkg.sv
// ----------------------------------------------------------------------------
// rix_pkg
// operation codes, widths and the per-stage record of the execute chain
// ----------------------------------------------------------------------------
package rix_pkg;
  localparam int XLEN   = 32;
  localparam int NSTAGE = 33;   // one stage per quotient bit, plus entry stage

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_SLL = 5'd2, OP_SLT = 5'd3, OP_SLTU = 5'd4,
    OP_XOR = 5'd5, OP_SRL = 5'd6, OP_SRA = 5'd7, OP_OR = 5'd8, OP_AND = 5'd9,
    OP_MUL = 5'd10, OP_MULH = 5'd11, OP_MULHSU = 5'd12, OP_MULHU = 5'd13,
    OP_DIV = 5'd14, OP_DIVU = 5'd15, OP_REM = 5'd16, OP_REMU = 5'd17,
    OP_EQ = 5'd18, OP_NE = 5'd19, OP_GE = 5'd20, OP_GEU = 5'd21
  } op_t;

  // state carried from cell to cell
  typedef struct packed {
    logic             vld;
    logic             is_div;   // quotient/remainder still being formed
    logic             want_rem;
    logic             neg_res;  // negate final value
    logic [XLEN-1:0]  rem;      // partial remainder
    logic [XLEN-1:0]  quo;      // dividend shifting out, quotient shifting in
    logic [XLEN-1:0]  dvs;      // divisor magnitude
    logic [XLEN-1:0]  res;      // finished result for non-divide ops
  } cell_t;
endpackage

### hdl/rix_front.sv
// ----------------------------------------------------------------------------
// rix_front
// entry cell: simple alu ops, multiply and divide operand setup
// ----------------------------------------------------------------------------
module rix_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [4:0]                  op,
  input  logic [rix_pkg::XLEN-1:0]    a,
  input  logic [rix_pkg::XLEN-1:0]    b,
  output rix_pkg::cell_t              cell_r
);
  rix_pkg::cell_t   cell_nxt;
  logic [4:0]       sh;
  logic [32:0]      ma, mb;
  logic [65:0]      prod;
  logic             slt, na, nb, sgn;

  assign sh  = b[4:0];
  assign slt = $signed(a) < $signed(b);

  always_comb begin
    ma = {op == rix_pkg::OP_MULH || op == rix_pkg::OP_MULHSU ? a[31] : 1'b0, a};
    mb = {op == rix_pkg::OP_MULH ? b[31] : 1'b0, b};
    prod = 66'($signed(ma) * $signed(mb));
    sgn  = op == rix_pkg::OP_DIV || op == rix_pkg::OP_REM;
    na   = sgn & a[31];
    nb   = sgn & b[31];
    cell_nxt = '0;
    cell_nxt.vld = in_vld;
    case (op)
      rix_pkg::OP_ADD:    cell_nxt.res = a + b;
      rix_pkg::OP_SUB:    cell_nxt.res = a - b;
      rix_pkg::OP_SLL:    cell_nxt.res = a << sh;
      rix_pkg::OP_SLT:    cell_nxt.res = {31'd0, slt};
      rix_pkg::OP_SLTU:   cell_nxt.res = {31'd0, a < b};
      rix_pkg::OP_XOR:    cell_nxt.res = a ^ b;
      rix_pkg::OP_SRL:    cell_nxt.res = a >> sh;
      rix_pkg::OP_SRA:    cell_nxt.res = 32'($signed(a) >>> sh);
      rix_pkg::OP_OR:     cell_nxt.res = a | b;
      rix_pkg::OP_AND:    cell_nxt.res = a & b;
      rix_pkg::OP_MUL:    cell_nxt.res = prod[31:0];
      rix_pkg::OP_MULH, rix_pkg::OP_MULHSU, rix_pkg::OP_MULHU:
                          cell_nxt.res = prod[63:32];
      rix_pkg::OP_DIV, rix_pkg::OP_DIVU, rix_pkg::OP_REM, rix_pkg::OP_REMU: begin
        if (b == '0) begin
          // divide by zero: all ones or the dividend
          cell_nxt.res = (op == rix_pkg::OP_REM || op == rix_pkg::OP_REMU) ? a : '1;
        end else begin
          // signed overflow falls out of the magnitude path naturally
          cell_nxt.is_div   = 1'b1;
          cell_nxt.want_rem = op == rix_pkg::OP_REM || op == rix_pkg::OP_REMU;
          cell_nxt.neg_res  = cell_nxt.want_rem ? na : (na ^ nb);
          cell_nxt.quo      = na ? -a : a;
          cell_nxt.dvs      = nb ? -b : b;
        end
      end
      rix_pkg::OP_EQ:     cell_nxt.res = {31'd0, a == b};
      rix_pkg::OP_NE:     cell_nxt.res = {31'd0, a != b};
      rix_pkg::OP_GE:     cell_nxt.res = {31'd0, !slt};
      rix_pkg::OP_GEU:    cell_nxt.res = {31'd0, a >= b};
      default:            cell_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end
endmodule

### hdl/rix_cell.sv
// ----------------------------------------------------------------------------
// rix_cell
// one restoring-division step; other ops pass straight through
// ----------------------------------------------------------------------------
module rix_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rix_pkg::cell_t cell_i,
  output rix_pkg::cell_t cell_r
);
  rix_pkg::cell_t cell_nxt;
  logic [32:0]    trial;
  logic [32:0]    diff;

  always_comb begin
    cell_nxt = cell_i;
    trial = {cell_i.rem, cell_i.quo[31]};
    diff  = trial - {1'b0, cell_i.dvs};
    if (cell_i.is_div) begin
      if (!diff[32]) begin
        cell_nxt.rem = diff[31:0];
        cell_nxt.quo = {cell_i.quo[30:0], 1'b1};
      end else begin
        cell_nxt.rem = trial[31:0];
        cell_nxt.quo = {cell_i.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end
endmodule

### hdl/rv32im_integer_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32im_integer_execute_unit_core
// rv32im alu with multiply and divide, as a chain of division cells
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: one operation per beat, accepted when in_tvalid and
//   in_tready are both high. result channel out_*: one 32-bit result per beat.
//   path: every operation passes the entry cell, every division cell and
//   the output register, so results come out in order. an entry cell
//   computes simple alu ops and the product; 32 division cells each
//   retire one quotient bit. throughput: one beat per cycle unless stalled;
//   every cell hands its contents on each cycle the chain advances.
//   stall: the whole chain and the output register move together; when
//   out_tready is low and the output register is full, the chain freezes
//   and in_tready drops in the same cycle.
//   reset: rst_n low clears all valid bits; no result is pending after it.
module rv32im_integer_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // req_type[4:0], operand_a[36:5], operand_b[68:37], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result[31:0]
);
  localparam int N = rix_pkg::NSTAGE;

  rix_pkg::cell_t chain [N];
  logic           adv;
  logic [31:0]    fin;
  logic           out_vld_r;
  logic [31:0]    out_data_r;

  // chain advances whenever output slot is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  rix_front u_front (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(in_tvalid),
    .op(in_tdata[4:0]), .a(in_tdata[36:5]), .b(in_tdata[68:37]),
    .cell_r(chain[0])
  );

  for (genvar i = 1; i < N; i++) begin : g_cell
    rix_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .cell_i(chain[i-1]), .cell_r(chain[i])
    );
  end

  // final select: remainder or quotient with sign fixup for divide results, res otherwise
  always_comb begin
    if (chain[N-1].is_div) begin
      fin = chain[N-1].want_rem ? chain[N-1].rem : chain[N-1].quo;
      if (chain[N-1].neg_res) begin
        fin = -fin;
      end
    end else begin
      fin = chain[N-1].res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r  <= chain[N-1].vld;
      out_data_r <= fin;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
endmodule

### hdl/rix_checker.sv
// ----------------------------------------------------------------------------
// rix_checker
// port-level checks on the execute unit
// ----------------------------------------------------------------------------
`include "rv32im_integer_execute_unit_core_macros.svh"
module rix_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  `RIX_ASSERT_NXT(a_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `RIX_ASSERT_NXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `RIX_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_tvalid, in_tready)
  `RIX_ASSERT_IMP(a_stall_blocks, clk, rst_n, out_tvalid && !out_tready, !in_tready)
endmodule

bind rv32im_integer_execute_unit_core rix_checker u_rix_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

### test/tb_rv32im_integer_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32im_integer_execute_unit_core
// drives directed and random operations into the execute unit and checks every
// result beat against an in-order queue of typed-in or behavioral alu results
// ----------------------------------------------------------------------------
module tb_rv32im_integer_execute_unit_core;

  localparam int N_RANDOM   = 1450;
  localparam int STALL_MAX  = 2000;   // cycles without any accepted beat
  localparam int DRAIN_WAIT = 40;     // pipeline depth plus margin
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;
  localparam logic [4:0]  SHAMT_MASK = 5'h1F;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;    // req_type[4:0], operand_a[36:5], operand_b[68:37], zeros
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // result[31:0]

  rv32im_integer_execute_unit_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle and stall percentages for the sender and receiver processes
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  logic [31:0] result_q[$];   // expected results, oldest first
  int          mismatches;
  int          idle_cycles;
  bit          timed_out;

  // behavioral alu: computes the expected result of one operation
  function automatic logic [31:0] alu_result(logic [4:0] code, logic [31:0] a,
                                             logic [31:0] b);
    logic signed [63:0] sa, sb, pss, psu;
    logic        [63:0] puu;
    logic signed [31:0] qa, qb;
    logic        [4:0]  sh;
    sa  = $signed({{32{a[31]}}, a});
    sb  = $signed({{32{b[31]}}, b});
    pss = sa * sb;
    psu = sa * $signed({32'd0, b});
    puu = {32'd0, a} * {32'd0, b};
    qa  = $signed(a);
    qb  = $signed(b);
    sh  = b[4:0] & SHAMT_MASK;
    case (code)
      rix_pkg::OP_ADD:    return a + b;
      rix_pkg::OP_SUB:    return a - b;
      rix_pkg::OP_SLL:    return a << sh;
      rix_pkg::OP_SLT:    return {31'd0, qa < qb};
      rix_pkg::OP_SLTU:   return {31'd0, a < b};
      rix_pkg::OP_XOR:    return a ^ b;
      rix_pkg::OP_SRL:    return a >> sh;
      rix_pkg::OP_SRA:    return qa >>> sh;
      rix_pkg::OP_OR:     return a | b;
      rix_pkg::OP_AND:    return a & b;
      rix_pkg::OP_MUL:    return puu[31:0];
      rix_pkg::OP_MULH:   return pss[63:32];
      rix_pkg::OP_MULHSU: return psu[63:32];
      rix_pkg::OP_MULHU:  return puu[63:32];
      rix_pkg::OP_DIV: begin
        if (b == 0) return WORD_MASK;
        if (a == SIGN_BIT && b == WORD_MASK) return SIGN_BIT;
        return qa / qb;
      end
      rix_pkg::OP_DIVU:   return (b == 0) ? WORD_MASK : a / b;
      rix_pkg::OP_REM: begin
        if (b == 0) return a;
        if (a == SIGN_BIT && b == WORD_MASK) return 32'd0;
        return qa % qb;
      end
      rix_pkg::OP_REMU:   return (b == 0) ? a : a % b;
      rix_pkg::OP_EQ:     return {31'd0, a == b};
      rix_pkg::OP_NE:     return {31'd0, a != b};
      rix_pkg::OP_GE:     return {31'd0, qa >= qb};
      rix_pkg::OP_GEU:    return {31'd0, a >= b};
      default:            return 32'd0;   // unused codes give zero
    endcase
  endfunction

  // directed table; known_res marks rows whose expected value is typed in
  typedef struct {
    logic [4:0]  code;
    logic [31:0] a;
    logic [31:0] b;
    bit          known_res;
    logic [31:0] res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{rix_pkg::OP_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0000_0000},
    '{rix_pkg::OP_SUB,    32'h0000_0000, 32'h0000_0001, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_SLL,    32'h0000_0001, 32'hFFFF_FFFF, 1, 32'h8000_0000},
    '{rix_pkg::OP_SLT,    32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0001},
    '{rix_pkg::OP_SLTU,   32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0000},
    '{rix_pkg::OP_XOR,    32'hAAAA_5555, 32'hFFFF_FFFF, 0, 32'h0},
    '{rix_pkg::OP_SRL,    32'h8000_0000, 32'h0000_001F, 1, 32'h0000_0001},
    '{rix_pkg::OP_SRA,    32'h8000_0000, 32'h0000_001F, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_OR,     32'h1234_0000, 32'h0000_5678, 0, 32'h0},
    '{rix_pkg::OP_AND,    32'hFFFF_FFFF, 32'h0F0F_F0F0, 0, 32'h0},
    '{rix_pkg::OP_MUL,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0001},
    '{rix_pkg::OP_MULH,   32'h8000_0000, 32'h8000_0000, 1, 32'h4000_0000},
    '{rix_pkg::OP_MULHSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_MULHU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFE},
    // divide by zero
    '{rix_pkg::OP_DIV,    32'h1234_5678, 32'h0000_0000, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_DIVU,   32'hFFFF_FFFF, 32'h0000_0000, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_REM,    32'h8765_4321, 32'h0000_0000, 1, 32'h8765_4321},
    '{rix_pkg::OP_REMU,   32'hFFFF_FFFF, 32'h0000_0000, 1, 32'hFFFF_FFFF},
    // signed overflow
    '{rix_pkg::OP_DIV,    32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h8000_0000},
    '{rix_pkg::OP_REM,    32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000},
    // rounding toward zero, remainder follows the dividend sign
    '{rix_pkg::OP_DIV,    32'hFFFF_FFF9, 32'h0000_0002, 1, 32'hFFFF_FFFD},
    '{rix_pkg::OP_REM,    32'hFFFF_FFF9, 32'h0000_0002, 1, 32'hFFFF_FFFF},
    '{rix_pkg::OP_EQ,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0001},
    '{rix_pkg::OP_NE,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000},
    '{rix_pkg::OP_GE,     32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0000},
    '{rix_pkg::OP_GEU,    32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0001},
    '{5'd31,              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000}
  };

  // one beat on the input channel; the expected result is queued at handshake
  task automatic send_op(logic [4:0] code, logic [31:0] a, logic [31:0] b,
                         bit known_res, logic [31:0] res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'd0, b, a, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_q.push_back(known_res ? res : alu_result(code, a, b));
  endtask

  // operands biased toward edges of the word
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return WORD_MASK;
      2:       return SIGN_BIT;
      3:       return $urandom_range(15);
      4:       return WORD_MASK - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, checks each result beat against the queue head
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: actual %08h", out_tdata);
        end else begin
          logic [31:0] want;
          want = result_q.pop_front();
          if (out_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %08h actual %08h", want, out_tdata);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: counts cycles with no accepted beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [4:0] code;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    timed_out      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_op(dir_rows[i].code, dir_rows[i].a, dir_rows[i].b,
              dir_rows[i].known_res, dir_rows[i].res);

    // random phases: none, sender idle, receiver stall, both, none again
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n * 5) / N_RANDOM;
      case (phase)
        1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
        3:       begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      // mostly defined ops, a few unused codes
      code = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 22))
                                       : 5'($urandom_range(21));
      send_op(code, pick_operand(), pick_operand(), 1'b0, 32'd0);
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
